// ===== hw/rtl/ddrp_pkg.sv =====
// Shared types, constants and helper functions of the differential drive ramp PWM block.
package ddrp_pkg;

	// request codes of the input item
	typedef enum logic [1:0] {
		REQ_DRIVE = 2'd0,
		REQ_TICK  = 2'd1,
		REQ_ESTOP = 2'd2
	} req_t;

	// register indexes of the configuration port
	localparam logic [1:0] REG_MAX_SPEED   = 2'd0;
	localparam logic [1:0] REG_ACCEL_STEP  = 2'd1;
	localparam logic [1:0] REG_INVERT_MASK = 2'd2;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [6:0]  MAX_SPEED_RST   = 7'd100;
	localparam logic [14:0] ACCEL_STEP_RST  = 15'd256;
	localparam logic [3:0]  INVERT_MASK_RST = 4'd0;

	localparam logic [6:0] PCT_LIMIT = 7'd100;

	// ceil(2^30 / 25): p * 256 / 100 == (p * RECIP_100) >> 24 for p up to 10000
	localparam logic [25:0] RECIP_100   = 26'd42949673;
	localparam int          RECIP_SHIFT = 24;

	// queue entry: request kind and, for a drive command, the new targets
	typedef struct packed {
		req_t               kind;
		logic signed [15:0] tgt_l;
		logic signed [15:0] tgt_r;
	} item_t;

	typedef logic [11:0] duty_lut_t [0:127];

	// clamp a mixed or raw command to plus minus 100
	function automatic logic signed [7:0] clamp100_f(input logic signed [8:0] v);
		logic signed [7:0] r;
		if (v > 9'sd100) begin
			r = 8'sd100;
		end else if (v < -9'sd100) begin
			r = -8'sd100;
		end else begin
			r = v[7:0];
		end
		return r;
	endfunction

	// move cur toward tgt by at most step, never past it
	function automatic logic signed [15:0] slew_f(input logic signed [15:0] cur,
			input logic signed [15:0] tgt, input logic [14:0] step);
		logic signed [17:0] cur_x;
		logic signed [17:0] tgt_x;
		logic signed [17:0] up;
		logic signed [17:0] dn;
		logic signed [15:0] r;
		cur_x = $signed({{2{cur[15]}}, cur});
		tgt_x = $signed({{2{tgt[15]}}, tgt});
		up    = cur_x + $signed({3'b000, step});
		dn    = cur_x - $signed({3'b000, step});
		if (cur < tgt) begin
			r = (up > tgt_x) ? tgt : up[15:0];
		end else if (cur > tgt) begin
			r = (dn < tgt_x) ? tgt : dn[15:0];
		end else begin
			r = cur;
		end
		return r;
	endfunction

	// direction pin levels: high exactly when forward equals the invert bit
	function automatic logic [3:0] pins_f(input logic signed [15:0] cur_l,
			input logic signed [15:0] cur_r, input logic [3:0] inv);
		logic fwd_l;
		logic fwd_r;
		fwd_l = ~cur_l[15];
		fwd_r = ~cur_r[15];
		return {fwd_r ~^ inv[3], fwd_r ~^ inv[2], fwd_l ~^ inv[1], fwd_l ~^ inv[0]};
	endfunction

	// percent to duty, evaluated at elaboration; codes above 100 act as 100
	function automatic duty_lut_t duty_lut_f();
		duty_lut_t lut;
		int        p;
		for (int i = 0; i < 128; i++) begin
			p = (i > 100) ? 100 : i;
			lut[i] = (p == 0) ? 12'd0 : 12'((p - 1) * 2095 / 99 + 2000);
		end
		return lut;
	endfunction

	localparam duty_lut_t DUTY_LUT = duty_lut_f();

endpackage

// ===== hw/rtl/diff_drive_ramp_pwm.sv =====
// Top level of the differential drive mixer with slew-limited speeds and PWM duty output.
//
// The block takes one item per clock while req_stall is low: a drive command (sets
// left/right targets from the mixed and scaled x/y commands), an update tick (ramps each
// speed toward its target and returns duties and direction pins), or an emergency stop
// (zeroes targets and speeds and returns zero duty with the pins held). A tick or stop
// passes two front stages (mix, then the scale by max_speed/100 through a reciprocal
// multiply), the short queue, then the ramp step and the duty lookup in the back end,
// and presents one result. Drive commands return nothing. The front end and back end each
// stall on their own, so a waiting result does not block new items until both back
// stages, the queue and both front stages fill. Registers sit on an APB-style port:
// max_speed at 0x0, accel_step at 0x4, invert_mask at 0x8; change them only while no
// item is in flight.
module diff_drive_ramp_pwm #(
	parameter int QUEUE_DEPTH = ddrp_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	// item channel
	input  logic                req_valid,
	output logic                req_stall,
	input  logic [1:0]          req_type,
	input  logic signed [7:0]   x_cmd,
	input  logic signed [7:0]   y_cmd,
	// result channel
	output logic                res_valid,
	input  logic                res_stall,
	output logic [11:0]         left_duty,
	output logic [11:0]         right_duty,
	output logic [3:0]          pin_levels,
	// configuration port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);

	logic [6:0]       max_speed_q;
	logic [14:0]      accel_step_q;
	logic [3:0]       invert_mask_q;
	logic             cfg_wr;

	logic             q_push;
	logic             q_full;
	ddrp_pkg::item_t  q_push_item;
	logic             q_pop;
	logic             q_vld;
	ddrp_pkg::item_t  q_pop_item;

	// configuration registers; writes to an index past the list drop silently
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_q   <= ddrp_pkg::MAX_SPEED_RST;
			accel_step_q  <= ddrp_pkg::ACCEL_STEP_RST;
			invert_mask_q <= ddrp_pkg::INVERT_MASK_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				ddrp_pkg::REG_MAX_SPEED:   max_speed_q   <= pwdata[6:0];
				ddrp_pkg::REG_ACCEL_STEP:  accel_step_q  <= pwdata[14:0];
				ddrp_pkg::REG_INVERT_MASK: invert_mask_q <= pwdata[3:0];
				default:                   max_speed_q   <= max_speed_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			ddrp_pkg::REG_MAX_SPEED:   prdata = {25'd0, max_speed_q};
			ddrp_pkg::REG_ACCEL_STEP:  prdata = {17'd0, accel_step_q};
			ddrp_pkg::REG_INVERT_MASK: prdata = {28'd0, invert_mask_q};
			default:                   prdata = 32'd0;
		endcase
	end

	// front: accept, classify, mix and scale
	ddrp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_type  (req_type),
		.x_cmd     (x_cmd),
		.y_cmd     (y_cmd),
		.max_speed (max_speed_q),
		.push_vld  (q_push),
		.push_full (q_full),
		.push_item (q_push_item)
	);

	// decouple the two halves
	ddrp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_vld  (q_push),
		.push_item (q_push_item),
		.full      (q_full),
		.pop       (q_pop),
		.pop_vld   (q_vld),
		.pop_item  (q_pop_item)
	);

	// back: hold state, ramp speeds, map to duty and pins
	ddrp_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pop_vld     (q_vld),
		.pop_item    (q_pop_item),
		.pop         (q_pop),
		.accel_step  (accel_step_q),
		.invert_mask (invert_mask_q),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.left_duty   (left_duty),
		.right_duty  (right_duty),
		.pin_levels  (pin_levels)
	);

`ifndef SYNTHESIS
	// the back end only takes an item the queue actually holds
	a_pop_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_vld)
		else $error("back end popped an empty queue");

	// a nonzero duty always starts at the dead-band floor
	a_left_duty_floor: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && left_duty != 12'd0) |-> (left_duty >= 12'd2000))
		else $error("left duty below floor");

	a_right_duty_floor: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && right_duty != 12'd0) |-> (right_duty >= 12'd2000))
		else $error("right duty below floor");
`endif

endmodule

// ===== hw/rtl/ddrp_front.sv =====
// Front end: accepts items, drops unused codes, mixes and scales drive commands into targets.
module ddrp_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  logic [1:0]          req_type,
	input  logic signed [7:0]   x_cmd,
	input  logic signed [7:0]   y_cmd,
	input  logic [6:0]          max_speed,
	output logic                push_vld,
	input  logic                push_full,
	output ddrp_pkg::item_t     push_item
);

	logic                accept;
	logic                take;
	logic                s1_free;
	logic                s2_free;
	logic signed [7:0]   xc;
	logic signed [7:0]   yc;
	logic signed [7:0]   mix_l;
	logic signed [7:0]   mix_r;
	logic [6:0]          mag_l;
	logic [6:0]          mag_r;
	logic [6:0]          lim;
	logic [39:0]         full_l;
	logic [39:0]         full_r;
	logic [14:0]         q_l;
	logic [14:0]         q_r;

	logic                vld_s1;
	ddrp_pkg::req_t      kind_s1;
	logic                neg_l_s1;
	logic                neg_r_s1;
	logic [13:0]         prod_l_s1;
	logic [13:0]         prod_r_s1;

	logic                vld_s2;
	ddrp_pkg::item_t     item_s2;

	assign s2_free   = ~vld_s2 | ~push_full;
	assign s1_free   = ~vld_s1 | s2_free;
	assign req_stall = ~s1_free;
	assign accept    = req_valid & ~req_stall;
	// drop the unused request code here
	assign take      = accept & (req_type != 2'b11);

	always_comb begin
		xc    = ddrp_pkg::clamp100_f({x_cmd[7], x_cmd});
		yc    = ddrp_pkg::clamp100_f({y_cmd[7], y_cmd});
		mix_l = ddrp_pkg::clamp100_f({yc[7], yc} + {xc[7], xc});
		mix_r = ddrp_pkg::clamp100_f({yc[7], yc} - {xc[7], xc});
		mag_l = mix_l[7] ? 7'(-mix_l) : mix_l[6:0];
		mag_r = mix_r[7] ? 7'(-mix_r) : mix_r[6:0];
		lim   = (max_speed > ddrp_pkg::PCT_LIMIT) ? ddrp_pkg::PCT_LIMIT : max_speed;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s1_free) begin
			vld_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free) begin
			kind_s1   <= ddrp_pkg::req_t'(req_type);
			neg_l_s1  <= mix_l[7];
			neg_r_s1  <= mix_r[7];
			prod_l_s1 <= 14'(mag_l * lim);
			prod_r_s1 <= 14'(mag_r * lim);
		end
	end

	// divide by 100 through the reciprocal
	always_comb begin
		full_l = 40'(prod_l_s1) * 40'(ddrp_pkg::RECIP_100);
		full_r = 40'(prod_r_s1) * 40'(ddrp_pkg::RECIP_100);
		q_l    = full_l[ddrp_pkg::RECIP_SHIFT +: 15];
		q_r    = full_r[ddrp_pkg::RECIP_SHIFT +: 15];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (s2_free) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free) begin
			item_s2.kind  <= kind_s1;
			item_s2.tgt_l <= neg_l_s1 ? -$signed({1'b0, q_l}) : $signed({1'b0, q_l});
			item_s2.tgt_r <= neg_r_s1 ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});
		end
	end

	assign push_vld  = vld_s2;
	assign push_item = item_s2;

endmodule

// ===== hw/rtl/ddrp_queue.sv =====
// Short item queue between the front end and the back end.
module ddrp_queue #(
	parameter int DEPTH = ddrp_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push_vld,
	input  ddrp_pkg::item_t     push_item,
	output logic                full,
	input  logic                pop,
	output logic                pop_vld,
	output ddrp_pkg::item_t     pop_item
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	ddrp_pkg::item_t mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;
	logic            do_push;
	logic            do_pop;

	assign full     = (cnt_q == CW'(DEPTH));
	assign pop_vld  = (cnt_q != '0);
	assign do_push  = push_vld & ~full;
	assign do_pop   = pop & pop_vld;
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!do_push && do_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/ddrp_back.sv =====
// Back end: holds targets and speeds, runs the slew step and drives duty and pin results.
module ddrp_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pop_vld,
	input  ddrp_pkg::item_t     pop_item,
	output logic                pop,
	input  logic [14:0]         accel_step,
	input  logic [3:0]          invert_mask,
	output logic                res_valid,
	input  logic                res_stall,
	output logic [11:0]         left_duty,
	output logic [11:0]         right_duty,
	output logic [3:0]          pin_levels
);

	logic signed [15:0] tgt_l_q;
	logic signed [15:0] tgt_r_q;
	logic signed [15:0] cur_l_q;
	logic signed [15:0] cur_r_q;
	logic [3:0]         pins_q;

	logic               vld_s1;
	logic signed [15:0] cur_l_s1;
	logic signed [15:0] cur_r_s1;
	logic [3:0]         pins_s1;

	logic               s1_free;
	logic               s2_free;
	logic               is_drive;
	logic               is_estop;
	logic signed [15:0] nxt_l;
	logic signed [15:0] nxt_r;
	logic [3:0]         nxt_pins;
	logic [15:0]        mag_l;
	logic [15:0]        mag_r;

	assign s2_free  = ~res_valid | ~res_stall;
	assign s1_free  = ~vld_s1 | s2_free;
	assign is_drive = (pop_item.kind == ddrp_pkg::REQ_DRIVE);
	assign is_estop = (pop_item.kind == ddrp_pkg::REQ_ESTOP);
	// a drive command only updates targets, so it never waits on the result side
	assign pop      = pop_vld & (is_drive | s1_free);

	always_comb begin
		nxt_l    = ddrp_pkg::slew_f(cur_l_q, tgt_l_q, accel_step);
		nxt_r    = ddrp_pkg::slew_f(cur_r_q, tgt_r_q, accel_step);
		nxt_pins = ddrp_pkg::pins_f(nxt_l, nxt_r, invert_mask);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tgt_l_q <= '0;
			tgt_r_q <= '0;
			cur_l_q <= '0;
			cur_r_q <= '0;
			pins_q  <= '0;
		end else if (pop) begin
			case (pop_item.kind)
				ddrp_pkg::REQ_DRIVE: begin
					tgt_l_q <= pop_item.tgt_l;
					tgt_r_q <= pop_item.tgt_r;
				end
				ddrp_pkg::REQ_TICK: begin
					cur_l_q <= nxt_l;
					cur_r_q <= nxt_r;
					pins_q  <= nxt_pins;
				end
				ddrp_pkg::REQ_ESTOP: begin
					tgt_l_q <= '0;
					tgt_r_q <= '0;
					cur_l_q <= '0;
					cur_r_q <= '0;
				end
				default: begin
					pins_q <= pins_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s1_free) begin
			vld_s1 <= pop & ~is_drive;
		end
	end

	// a stop carries zero speeds, which map to zero duty, and the held pins
	always_ff @(posedge clk) begin
		if (s1_free) begin
			cur_l_s1 <= is_estop ? 16'sd0 : nxt_l;
			cur_r_s1 <= is_estop ? 16'sd0 : nxt_r;
			pins_s1  <= is_estop ? pins_q : nxt_pins;
		end
	end

	always_comb begin
		mag_l = cur_l_s1[15] ? 16'(-cur_l_s1) : cur_l_s1;
		mag_r = cur_r_s1[15] ? 16'(-cur_r_s1) : cur_r_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (s2_free) begin
			res_valid <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free) begin
			left_duty  <= ddrp_pkg::DUTY_LUT[mag_l[14:8]];
			right_duty <= ddrp_pkg::DUTY_LUT[mag_r[14:8]];
			pin_levels <= pins_s1;
		end
	end

endmodule
